>>> rtl/core/ilha_pkg.sv
// Package for the implicit-list heap allocator: item types, constants, mode codes.
// No dependencies.
`timescale 1ns / 1ps
package ilha_pkg;

   localparam logic [16:0] CHUNK_RESET = 17'd256;
   localparam logic [16:0] MIN_BLOCK = 17'd16;
   localparam logic [16:0] FIRST_PAYLOAD = 17'd24;

   typedef enum logic [0:0] {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } mode_type;

   typedef struct packed {
      logic [0:0]  mode;
      logic [15:0] request_size;
      logic [15:0] payload_address;
   } req_type;

   typedef struct packed {
      logic [15:0] result_address;
      logic        success;
   } rsp_type;

endpackage

>>> rtl/core/ilha_if.sv
// Valid/ready channel interface for the allocator's items.
// Depends on ilha_pkg for nothing but is generic over a payload type.
`timescale 1ns / 1ps
interface ilha_if #(parameter type payload_type = logic [0:0]);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/implicit_list_heap_allocator_top.sv
// Implicit-list first-fit heap allocator with boundary tags.
// Depends on ilha_pkg, ilha_if, ilha_ram.
`timescale 1ns / 1ps
// Usage:
//  req channel: mode (0 allocate, 1 free), request_size, payload_address.
//  rsp channel: result_address, success; one rsp item per req item.
//  csr channel: writes extend_chunk (minimum heap growth in bytes); it is
//  always ready. The user must write it only while no item is in flight;
//  the block does not enforce this.
//  One item is worked at a time by a sequencer over one single-port word
//  memory: a write passes S_WR then S_STEP, a read S_RD, S_RDW and S_STEP
//  (address, data, use). An allocate walks blocks in a first-fit search,
//  then places and splits the block; when no block fits it grows the heap,
//  and a refused growth ends the item without success. The first allocate
//  also sets up the prologue and epilogue.
//  req ready is low from accept until the result has been taken. The result
//  sits in an output register; a stalled rsp receiver just holds the block
//  in the done state.
//  Reset clears break, setup flag and extend_chunk (to 256); memory contents
//  are left undefined and are only read after being written.
module implicit_list_heap_allocator_top #(
   parameter int unsigned HEAP_BYTES = 65536
) (
   input logic clock,
   input logic reset,
   ilha_if.sink   req,
   ilha_if.source rsp,
   ilha_if.sink   csr
);
   localparam int unsigned DEPTH = HEAP_BYTES / 8;
   localparam int unsigned IW = $clog2(DEPTH);
   localparam int unsigned HB_W = $clog2(HEAP_BYTES);
   // tag word holds a size up to the heap size plus the allocated bit
   localparam int unsigned WW = (HB_W + 1 > 17) ? HB_W + 1 : 17;
   // byte offsets also hold a full growth request past the break
   localparam int unsigned BW = (HB_W + 2 > 19) ? HB_W + 2 : 19;
   localparam logic [BW-1:0] HEAP_TOP = BW'(HEAP_BYTES);

   // one-hot sequencer; each op is a tagged micro-step
   typedef enum logic [15:0] {
      S_IDLE  = 16'h0001,
      S_RD    = 16'h0002,  // issue read
      S_RDW   = 16'h0004,  // data valid next
      S_STEP  = 16'h0008,  // act on read data
      S_WR    = 16'h0010,  // issue write
      S_DONE  = 16'h0020
   } state_type;

   // micro program points
   typedef enum logic [23:0] {
      P_SET0   = 24'h000001,
      P_SET1   = 24'h000002,
      P_SET2   = 24'h000004,
      P_GROW   = 24'h000008,
      P_GROW1  = 24'h000010,
      P_GROW2  = 24'h000020,
      P_GROW3  = 24'h000040,
      P_MRG0   = 24'h000080,
      P_MRG1   = 24'h000100,
      P_MRG2   = 24'h000200,
      P_MRG3   = 24'h000400,
      P_MRG4   = 24'h000800,
      P_MRGW0  = 24'h001000,
      P_MRGW1  = 24'h002000,
      P_FIT    = 24'h004000,
      P_PLACE  = 24'h008000,
      P_PLW0   = 24'h010000,
      P_PLW1   = 24'h020000,
      P_PLW2   = 24'h040000,
      P_PLW3   = 24'h080000,
      P_FREE0  = 24'h100000,
      P_FREEW0 = 24'h200000,
      P_FREEW1 = 24'h400000,
      P_FIN    = 24'h800000
   } pc_type;

   state_type st_ff, st_in;
   pc_type pc_ff, pc_in, ret_ff, ret_in;
   logic [16:0] chunk_ff, chunk_in;
   logic [BW-1:0] brk_ff, brk_in;
   logic ready_ff, ready_in;
   logic mode_ff, mode_in;
   logic [BW-1:0] asize_ff, asize_in, blk_ff, blk_in, sz_ff, sz_in;
   logic [BW-1:0] prv_ff, prv_in, tmp_ff, tmp_in;
   logic pa_ff, pa_in, na_ff, na_in;
   logic setup_ff, setup_in;
   logic [BW-1:0] addr_ff, addr_in;
   logic [WW-1:0] wdat_ff, wdat_in;
   ilha_pkg::rsp_type out_ff, out_in;

   logic          ram_we;
   logic [IW-1:0] ram_addr;
   logic [WW-1:0] ram_q;
   logic [WW-1:0] rdat;
   logic          oob_ff, oob_in;
   logic [BW-1:0] rsz;
   logic          ralc;

   ilha_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(wdat_ff),
      .rd_data(ram_q)
   );

   assign ram_we = (st_ff == S_WR) && (addr_ff < HEAP_TOP);
   assign ram_addr = addr_ff[IW+2:3];
   assign rdat = oob_ff ? WW'(1) : ram_q;
   assign rsz = BW'({rdat[WW-1:4], 4'd0});
   assign ralc = rdat[0];

   assign req.ready = (st_ff == S_IDLE);
   assign rsp.valid = (st_ff == S_DONE);
   assign rsp.payload = out_ff;
   assign csr.ready = 1'b1;

   always_comb begin
      logic [BW-1:0] r, ext;
      st_in = st_ff; pc_in = pc_ff; ret_in = ret_ff; chunk_in = chunk_ff;
      brk_in = brk_ff; ready_in = ready_ff; mode_in = mode_ff;
      asize_in = asize_ff; blk_in = blk_ff; sz_in = sz_ff; prv_in = prv_ff;
      tmp_in = tmp_ff; pa_in = pa_ff; na_in = na_ff; setup_in = setup_ff;
      addr_in = addr_ff; wdat_in = wdat_ff; out_in = out_ff; oob_in = oob_ff;
      r = '0;
      ext = '0;
      if (csr.valid) begin
         chunk_in = csr.payload;
      end
      unique case (st_ff)
         S_IDLE: begin
            if (req.valid) begin
               mode_in = req.payload.mode;
               out_in = '0;
               r = BW'(req.payload.request_size) + BW'(31);
               asize_in = {r[BW-1:4], 4'd0};
               if (req.payload.mode == ilha_pkg::MODE_ALLOC) begin
                  if (req.payload.request_size == 16'd0) begin
                     st_in = S_DONE;
                  end else if (!ready_ff) begin
                     addr_in = '0; wdat_in = WW'(ilha_pkg::MIN_BLOCK) | WW'(1);
                     pc_in = P_SET0; st_in = S_WR;
                  end else begin
                     blk_in = BW'(16); pc_in = P_FIT; st_in = S_STEP;
                  end
               end else if (req.payload.payload_address == 16'd0) begin
                  out_in.success = 1'b1; st_in = S_DONE;
               end else if (BW'(req.payload.payload_address) <
                            BW'(ilha_pkg::FIRST_PAYLOAD) ||
                            BW'(req.payload.payload_address) >= brk_ff) begin
                  st_in = S_DONE;
               end else begin
                  blk_in = BW'(req.payload.payload_address) - BW'(8);
                  addr_in = BW'(req.payload.payload_address) - BW'(8);
                  pc_in = P_FREE0; st_in = S_RD;
               end
            end
         end
         S_RD: begin
            oob_in = addr_ff >= HEAP_TOP;
            st_in = S_RDW;
         end
         S_RDW: st_in = S_STEP;
         S_WR: st_in = S_STEP;
         S_DONE: begin
            if (rsp.ready) st_in = S_IDLE;
         end
         default: begin  // S_STEP: sequencer body
            st_in = S_STEP;
            unique case (pc_ff)
               P_SET0: begin addr_in = BW'(8);
                  wdat_in = WW'(ilha_pkg::MIN_BLOCK) | WW'(1); pc_in = P_SET1;
                  st_in = S_WR; end
               P_SET1: begin addr_in = BW'(16); wdat_in = WW'(1); pc_in = P_SET2;
                  st_in = S_WR; end
               P_SET2: begin
                  ready_in = 1'b1; brk_in = BW'(ilha_pkg::FIRST_PAYLOAD);
                  r = BW'(chunk_ff) + BW'(15);
                  tmp_in = {r[BW-1:4], 4'd0};
                  setup_in = 1'b1; pc_in = P_GROW;
               end
               P_GROW: begin
                  // tmp = rounded growth size
                  if (brk_ff + tmp_ff > HEAP_TOP || tmp_ff == '0) begin
                     if (setup_ff) begin
                        setup_in = 1'b0; blk_in = BW'(16); pc_in = P_FIT;
                     end else begin
                        pc_in = P_FIN;
                     end
                  end else begin
                     blk_in = brk_ff - BW'(8); sz_in = tmp_ff;
                     addr_in = brk_ff - BW'(8); wdat_in = WW'(tmp_ff);
                     pc_in = P_GROW1; st_in = S_WR;
                  end
               end
               P_GROW1: begin addr_in = blk_ff + sz_ff - BW'(8); pc_in = P_GROW2;
                  st_in = S_WR; end
               P_GROW2: begin addr_in = blk_ff + sz_ff; wdat_in = WW'(1);
                  pc_in = P_GROW3; st_in = S_WR; end
               P_GROW3: begin
                  brk_in = brk_ff + sz_ff;
                  ret_in = setup_ff ? P_FIT : P_PLACE;
                  addr_in = blk_ff - BW'(8); pc_in = P_MRG0; st_in = S_RD;
               end
               // merge: sz_ff = block size, blk_ff = block
               P_MRG0: begin
                  prv_in = blk_ff - rsz; addr_in = blk_ff - rsz;
                  pc_in = P_MRG1; st_in = S_RD;
               end
               P_MRG1: begin
                  pa_in = ralc; addr_in = blk_ff + sz_ff; pc_in = P_MRG2; st_in = S_RD;
               end
               P_MRG2: begin
                  na_in = ralc; tmp_in = rsz;
                  if (pa_ff && ralc) begin
                     pc_in = P_MRG4;
                  end else if (pa_ff) begin
                     sz_in = sz_ff + rsz; pc_in = P_MRGW0;
                  end else begin
                     addr_in = prv_ff; pc_in = P_MRG3; st_in = S_RD;
                  end
               end
               P_MRG3: begin
                  sz_in = sz_ff + rsz + (na_ff ? '0 : tmp_ff);
                  blk_in = prv_ff; pc_in = P_MRGW0;
               end
               P_MRGW0: begin addr_in = blk_ff; wdat_in = WW'(sz_ff);
                  pc_in = P_MRGW1; st_in = S_WR; end
               P_MRGW1: begin addr_in = blk_ff + sz_ff - BW'(8); pc_in = P_MRG4;
                  st_in = S_WR; end
               P_MRG4: begin
                  if (mode_ff == ilha_pkg::MODE_FREE) begin
                     out_in.success = 1'b1; pc_in = P_FIN;
                  end else if (ret_ff == P_FIT) begin
                     setup_in = 1'b0; blk_in = BW'(16); pc_in = P_FIT;
                  end else begin
                     pc_in = P_PLACE;
                  end
               end
               // first fit: read header at blk (two visits: issue, then check)
               P_FIT: begin
                  if (blk_ff >= brk_ff) begin
                     ext = asize_ff > BW'(chunk_ff) ? asize_ff : BW'(chunk_ff);
                     r = ext + BW'(15); tmp_in = {r[BW-1:4], 4'd0}; pc_in = P_GROW;
                  end else begin
                     addr_in = blk_ff; pc_in = P_PLW3; ret_in = P_FIT; st_in = S_RD;
                  end
               end
               P_PLW3: begin
                  if (ret_ff == P_FIT) begin
                     if (rsz == '0) begin
                        ext = asize_ff > BW'(chunk_ff) ? asize_ff : BW'(chunk_ff);
                        r = ext + BW'(15); tmp_in = {r[BW-1:4], 4'd0}; pc_in = P_GROW;
                     end else if (!ralc && asize_ff <= rsz) begin
                        sz_in = rsz; pc_in = P_PLW0;
                     end else begin
                        blk_in = blk_ff + rsz; pc_in = P_FIT;
                     end
                  end else begin
                     // all placement tags done
                     out_in.result_address = 16'(blk_ff + BW'(8));
                     out_in.success = 1'b1; pc_in = P_FIN;
                  end
               end
               P_PLACE: begin addr_in = blk_ff; pc_in = P_FREEW1; ret_in = P_PLACE;
                  st_in = S_RD; end
               P_PLW0: begin
                  // sz_ff = block size; place, splitting if the remainder is at least MIN_BLOCK
                  ret_in = P_PLACE;
                  if (sz_ff - asize_ff >= BW'(ilha_pkg::MIN_BLOCK)) begin
                     addr_in = blk_ff; wdat_in = WW'(asize_ff) | WW'(1);
                     pc_in = P_PLW1; st_in = S_WR;
                  end else begin
                     addr_in = blk_ff; wdat_in = WW'(sz_ff) | WW'(1);
                     tmp_in = '0; pc_in = P_PLW1; st_in = S_WR;
                  end
               end
               P_PLW1: begin
                  if (sz_ff - asize_ff >= BW'(ilha_pkg::MIN_BLOCK)) begin
                     addr_in = blk_ff + asize_ff - BW'(8); pc_in = P_PLW2;
                  end else begin
                     addr_in = blk_ff + sz_ff - BW'(8); pc_in = P_PLW3;
                  end
                  st_in = S_WR;
               end
               P_PLW2: begin
                  // remainder tags: header then footer
                  if (addr_ff == blk_ff + asize_ff - BW'(8)) begin
                     addr_in = blk_ff + asize_ff; wdat_in = WW'(sz_ff - asize_ff);
                     st_in = S_WR;
                  end else begin
                     addr_in = blk_ff + sz_ff - BW'(8); pc_in = P_PLW3; st_in = S_WR;
                  end
               end
               P_FREE0: begin
                  sz_in = rsz; addr_in = blk_ff; wdat_in = WW'(rsz);
                  pc_in = P_FREEW0; st_in = S_WR;
               end
               P_FREEW0: begin addr_in = blk_ff + sz_ff - BW'(8); ret_in = P_FIN;
                  pc_in = P_FREEW1; st_in = S_WR; end
               P_FREEW1: begin
                  if (ret_ff == P_PLACE) begin
                     sz_in = rsz; pc_in = P_PLW0;
                  end else begin
                     addr_in = blk_ff - BW'(8); pc_in = P_MRG0; st_in = S_RD;
                  end
               end
               default: st_in = S_DONE;
            endcase
         end
      endcase
   end

   // advance sequencer and hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; chunk_ff <= ilha_pkg::CHUNK_RESET; brk_ff <= '0;
         ready_ff <= 1'b0; setup_ff <= 1'b0;
      end else begin
         st_ff <= st_in; chunk_ff <= chunk_in; brk_ff <= brk_in;
         ready_ff <= ready_in; setup_ff <= setup_in;
      end
      pc_ff <= pc_in; ret_ff <= ret_in; mode_ff <= mode_in; asize_ff <= asize_in;
      blk_ff <= blk_in; sz_ff <= sz_in; prv_ff <= prv_in; tmp_ff <= tmp_in;
      pa_ff <= pa_in; na_ff <= na_in; addr_ff <= addr_in; wdat_ff <= wdat_in;
      out_ff <= out_in; oob_ff <= oob_in;
   end
endmodule

>>> rtl/core/ilha_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ilha_ram #(
   parameter int unsigned WIDTH = 17,
   parameter int unsigned DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write or read one word per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
